FILE: hdl/sacp_pkg.sv
// ----------------------------------------------------------------------------
// sacp_pkg
// shared constants for the set associative cache with next-line prefetch
// ----------------------------------------------------------------------------
package sacp_pkg;

   localparam logic [2:0] REG_REPLACE_LRU = 3'd0;
   localparam logic [2:0] REG_PREFETCH_ON = 3'd1;
   localparam logic [2:0] REG_BLOCK_BITS  = 3'd2;
   localparam logic [2:0] REG_SET_BITS    = 3'd3;
   localparam logic [2:0] REG_WAYS        = 3'd4;

   localparam int CSR_ADDR_BITS = 5;

   // hit in bit 0, reads in bits 2:1, write flag in bit 3
   typedef struct packed {
      logic       wr;
      logic [1:0] reads;
      logic       hit;
   } rsp_type;

endpackage

FILE: hdl/set_assoc_cache_prefetch_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_prefetch_sim
// set associative cache with fifo or lru replacement and next-line prefetch
// ----------------------------------------------------------------------------
// lookup: a hit walks the tags of the set way by way up to the matching way;
//   a miss in a full set walks all tags and then scans the stamps, and the
//   prefetch probe of the next block walks its set in the same way
// throughput: one transaction at a time, next accept in the cycle after the
//   response is loaded; the single compare unit walking the set sets the rate
// reset: synchronous; clears fill counts, stamp counter, config and control
module set_assoc_cache_prefetch_sim
   import sacp_pkg::*;
#(
   parameter int MAX_SETS   = 256,
   parameter int MAX_WAYS   = 8,
   parameter int ADDR_BITS  = 48,
   parameter int STAMP_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: address, is_write (zero pad to bytes)
   input  logic [((ADDR_BITS+1+7)/8)*8-1:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: hit[0], memory_reads[2:1], memory_write[3], pad
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SB  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WB  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int LSB = $clog2(MAX_SETS + 1) - 1;  // largest usable set_bits
   localparam int DEPTH = MAX_SETS * MAX_WAYS;
   localparam int EB  = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
   localparam int CB  = $clog2(MAX_WAYS + 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;  // split address, read fill count
   localparam logic [2:0] ST_RD    = 3'd2;  // issue memory read for one way
   localparam logic [2:0] ST_CMP   = 3'd3;  // compare tag / stamp of that way
   localparam logic [2:0] ST_WR    = 3'd4;  // write tag/stamp
   localparam logic [2:0] ST_OUT   = 3'd5;

   // configuration
   logic       lru_ff, pf_ff;
   logic [3:0] bb_ff, sbits_ff, ways_ff;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         lru_ff <= 1'b0; pf_ff <= 1'b0; bb_ff <= 4'd5; sbits_ff <= 4'd0; ways_ff <= 4'd1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[CSR_ADDR_BITS-1:2])
            REG_REPLACE_LRU: lru_ff   <= csr_pwdata[0];
            REG_PREFETCH_ON: pf_ff    <= csr_pwdata[0];
            REG_BLOCK_BITS:  bb_ff    <= csr_pwdata[3:0];
            REG_SET_BITS:    sbits_ff <= csr_pwdata[3:0];
            REG_WAYS:        ways_ff  <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (csr_paddr[CSR_ADDR_BITS-1:2])
         REG_REPLACE_LRU: csr_prdata = {31'd0, lru_ff};
         REG_PREFETCH_ON: csr_prdata = {31'd0, pf_ff};
         REG_BLOCK_BITS:  csr_prdata = {28'd0, bb_ff};
         REG_SET_BITS:    csr_prdata = {28'd0, sbits_ff};
         REG_WAYS:        csr_prdata = {28'd0, ways_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // effective geometry
   logic [3:0]  esb;
   logic [CB-1:0] ew;
   always_comb begin
      esb = (32'(sbits_ff) > LSB) ? 4'(LSB) : sbits_ff;
      if (ways_ff == 4'd0)               ew = CB'(1);
      else if (32'(ways_ff) > MAX_WAYS)  ew = CB'(MAX_WAYS);
      else                               ew = CB'(ways_ff);
   end

   // memories
   logic [ADDR_BITS-1:0]  tag_mem   [DEPTH];
   logic [STAMP_BITS-1:0] stamp_mem [DEPTH];
   logic [CB-1:0]         fill_mem  [MAX_SETS];
   logic [ADDR_BITS-1:0]  tag_rd_ff;
   logic [STAMP_BITS-1:0] stamp_rd_ff;
   logic [CB-1:0]         fmem_rd_ff;
   logic                  fvld_rd_ff;
   logic [CB-1:0]         fill_rd;
   // fill counts: reset clears them through a valid bit per set
   logic [MAX_SETS-1:0]   fvalid_ff;

   // control and datapath registers
   logic [2:0]            state_ff, state_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic                  wr_ff, wr_in;
   logic [SB-1:0]         set_ff, set_in;
   logic [ADDR_BITS-1:0]  tag_ff, tag_in;
   logic [CB-1:0]         n_ff, n_in;       // lines valid in this probe
   logic [WB-1:0]         way_ff, way_in;   // scan index
   logic                  scan_ff, scan_in; // 0 lookup, 1 victim search
   logic [WB-1:0]         vic_ff, vic_in;
   logic [STAMP_BITS-1:0] best_ff, best_in;
   logic                  pfp_ff, pfp_in;   // working on prefetch probe
   logic                  hit_ff, hit_in;
   logic [1:0]            reads_ff, reads_in;
   logic [STAMP_BITS-1:0] cnt_ff, cnt_in;
   logic                  fw_ff, fw_in;     // fill-count increment pending
   rsp_type               rsp_ff, rsp_in;
   logic                  ovalid_ff, ovalid_in;

   logic                  mem_we, stamp_only, fill_we;
   logic [EB-1:0]         mem_wa, mem_ra;
   logic [ADDR_BITS-1:0]  shifted;
   logic [STAMP_BITS-1:0] cnt_inc;

   // the response register frees the sequencer; ST_OUT waits for it to empty
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.wr, rsp_ff.reads, rsp_ff.hit};
   assign cnt_inc = (&cnt_ff) ? cnt_ff : cnt_ff + STAMP_BITS'(1);
   assign shifted = addr_ff >> bb_ff;
   assign mem_ra  = EB'(32'(set_ff) * MAX_WAYS + 32'(way_ff));
   assign fill_rd = fvld_rd_ff ? fmem_rd_ff : '0;

   always_comb begin
      state_in = state_ff; addr_in = addr_ff; wr_in = wr_ff; set_in = set_ff;
      tag_in = tag_ff; n_in = n_ff; way_in = way_ff; scan_in = scan_ff;
      vic_in = vic_ff; best_in = best_ff; pfp_in = pfp_ff; hit_in = hit_ff;
      reads_in = reads_ff; cnt_in = cnt_ff; fw_in = 1'b0; rsp_in = rsp_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      mem_we = 1'b0; stamp_only = 1'b0; fill_we = 1'b0;
      mem_wa = EB'(32'(set_ff) * MAX_WAYS + 32'(way_ff));
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               addr_in  = req_tdata[ADDR_BITS-1:0];
               wr_in    = req_tdata[ADDR_BITS];
               cnt_in   = cnt_inc;
               pfp_in   = 1'b0; reads_in = 2'd0; hit_in = 1'b0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            set_in  = SB'(shifted & ((ADDR_BITS'(1) << esb) - ADDR_BITS'(1)));
            tag_in  = shifted >> esb;
            way_in  = '0; scan_in = 1'b0;
            state_in = ST_RD;
         end
         ST_RD: begin
            // fill count of the set is now readable
            if (way_ff == '0 && !scan_ff)
               n_in = (fill_rd < ew) ? fill_rd : ew;
            state_in = ST_CMP;
            if (way_ff == '0 && !scan_ff &&
                ((fill_rd < ew) ? fill_rd : ew) == '0) begin
               // empty set: fill way 0
               vic_in = '0; fw_in = 1'b1; state_in = ST_WR;
            end
         end
         ST_CMP: begin
            if (!scan_ff) begin
               if (tag_rd_ff == tag_ff) begin
                  if (!pfp_ff) begin
                     hit_in = 1'b1;
                     if (lru_ff) begin
                        mem_we = 1'b1; stamp_only = 1'b1;
                     end
                  end
                  state_in = ST_OUT;
               end else if (CB'(way_ff) + CB'(1) < n_ff) begin
                  way_in = way_ff + WB'(1); state_in = ST_RD;
               end else if (n_ff < ew) begin
                  vic_in = WB'(n_ff); fw_in = 1'b1; state_in = ST_WR;
               end else begin
                  scan_in = 1'b1; way_in = '0; state_in = ST_RD;
               end
            end else begin
               if (way_ff == '0 || stamp_rd_ff < best_ff) begin
                  best_in = stamp_rd_ff; vic_in = way_ff;
               end
               if (CB'(way_ff) + CB'(1) < ew) begin
                  way_in = way_ff + WB'(1); state_in = ST_RD;
               end else begin
                  state_in = ST_WR;
               end
            end
         end
         ST_WR: begin
            mem_we = 1'b1;
            mem_wa = EB'(32'(set_ff) * MAX_WAYS + 32'(vic_ff));
            fill_we = fw_ff;
            reads_in = reads_ff + 2'd1;
            state_in = ST_OUT;
            if (!pfp_ff && pf_ff) begin
               pfp_in = 1'b1;
               addr_in = addr_ff + (ADDR_BITS'(1) << bb_ff);
               cnt_in = cnt_inc;
               state_in = ST_SETUP;
            end
         end
         ST_OUT: begin
            if (!ovalid_ff) begin
               rsp_in = '{hit: hit_ff, reads: reads_ff, wr: wr_ff};
               ovalid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_CMP && !scan_ff && tag_rd_ff != tag_ff &&
          !(CB'(way_ff) + CB'(1) < n_ff) && n_ff < ew)
         fw_in = 1'b1;
      if (state_ff == ST_RD && fw_in) fw_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      tag_rd_ff   <= tag_mem[mem_ra];
      stamp_rd_ff <= stamp_mem[mem_ra];
      if (mem_we) begin
         stamp_mem[mem_wa] <= cnt_ff;
         if (!stamp_only) tag_mem[mem_wa] <= tag_ff;
      end
   end

   // fill count read follows the set being split, so it is ready in ST_RD
   always_ff @(posedge clock) begin
      fmem_rd_ff <= fill_mem[set_in];
      if (fill_we) fill_mem[set_ff] <= CB'(vic_ff) + CB'(1);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff  <= '0;
         fvld_rd_ff <= 1'b0;
      end else begin
         fvld_rd_ff <= fvalid_ff[set_in];
         if (fill_we) fvalid_ff[set_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; cnt_ff <= '0; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; ovalid_ff <= ovalid_in;
      end
      addr_ff <= addr_in; wr_ff <= wr_in; set_ff <= set_in; tag_ff <= tag_in;
      n_ff <= (state_ff == ST_SETUP) ? n_ff : n_in;
      way_ff <= way_in; scan_ff <= scan_in; vic_ff <= vic_in; best_ff <= best_in;
      pfp_ff <= pfp_in; hit_ff <= hit_in; reads_ff <= reads_in; fw_ff <= fw_in;
      rsp_ff <= rsp_in;
   end

endmodule

FILE: tb/set_assoc_cache_prefetch_sim_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_prefetch_sim_test
// checks the set associative cache with next-line prefetch against a model
// of its tag and stamp stores, over several replacement, prefetch, block,
// set and way settings, with random gaps on the request and response sides
// ----------------------------------------------------------------------------
module set_assoc_cache_prefetch_sim_test;
   import sacp_pkg::*;

   localparam int NSETS = 256;
   localparam int NWAYS = 8;
   localparam int ABITS = 48;
   localparam logic [31:0] STAMP_MAX = 32'hffff_ffff;

   // one request transaction: address in the low bits, write flag above it
   typedef struct packed {
      logic        is_write;
      logic [47:0] address;
   } access_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [55:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   set_assoc_cache_prefetch_sim u_top (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata),   // address[47:0], is_write[48], pad
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),   // hit[0], memory_reads[2:1], memory_write[3], pad
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cache model state
   logic [47:0] tags   [NSETS*NWAYS];
   logic [31:0] stamps [NSETS*NWAYS];
   logic [3:0]  fills  [NSETS];
   logic [31:0] stamp_now;
   logic        cfg_lru, cfg_pf;
   logic [3:0]  cfg_block, cfg_sets, cfg_ways;

   access_type  pending_access[$];
   rsp_type     expected_rsp[$];
   int          error_count = 0;
   int          accepted = 0, checked = 0, hit_count = 0, prefetch_count = 0;
   bit          hold_req = 1'b0;
   bit          stim_done = 1'b0;

   task automatic report(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic int used_ways();
      if (cfg_ways == 0) return 1;
      if (cfg_ways > NWAYS) return NWAYS;
      return int'(cfg_ways);
   endfunction

   function automatic int used_set_bits();
      return (cfg_sets > 8) ? 8 : int'(cfg_sets);
   endfunction

   function automatic void split_addr(input logic [47:0] a, output int s,
                                      output logic [47:0] t);
      int sb;
      logic [63:0] wide;
      sb = used_set_bits();
      wide = {16'd0, a} >> cfg_block;
      s = int'(wide & ((64'd1 << sb) - 1));
      t = 48'({16'd0, a} >> (cfg_block + sb));
   endfunction

   function automatic bit probe(input int s, input logic [47:0] t, input bit touch);
      int n;
      n = (int'(fills[s]) < used_ways()) ? int'(fills[s]) : used_ways();
      for (int u = 0; u < n; u++) begin
         if (tags[s*NWAYS+u] == t) begin
            if (touch) stamps[s*NWAYS+u] = stamp_now;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void allocate(input int s, input logic [47:0] t);
      int w, way;
      logic [31:0] best;
      w = used_ways();
      way = 0;
      if (int'(fills[s]) < w) begin
         way = int'(fills[s]);
         fills[s] = fills[s] + 4'd1;
      end else begin
         best = stamps[s*NWAYS];
         for (int r = 1; r < w; r++)
            if (stamps[s*NWAYS+r] < best) begin
               best = stamps[s*NWAYS+r];
               way = r;
            end
      end
      tags[s*NWAYS+way] = t;
      stamps[s*NWAYS+way] = stamp_now;
   endfunction

   function automatic rsp_type predict_access(input access_type acc);
      rsp_type r;
      int s;
      logic [47:0] t, nxt;
      r = '0;
      r.wr = acc.is_write;
      if (stamp_now != STAMP_MAX) stamp_now++;
      split_addr(acc.address, s, t);
      r.hit = probe(s, t, cfg_lru);
      if (!r.hit) begin
         allocate(s, t);
         r.reads = 2'd1;
         if (cfg_pf) begin
            nxt = acc.address + (48'd1 << cfg_block);
            if (stamp_now != STAMP_MAX) stamp_now++;
            split_addr(nxt, s, t);
            if (!probe(s, t, 1'b0)) begin
               allocate(s, t);
               r.reads = 2'd2;
            end
         end
      end
      return r;
   endfunction

   // short gaps mostly, now and then a long one
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver: presents queued accesses, predicting each when it is accepted
   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(predict_access(pending_access.pop_front()));
            accepted++;
            req_gap = gap_len();
         end
         if (req_tvalid && !req_tready) begin
            // hold the current transaction
         end else if (req_gap > 0 || hold_req || pending_access.size() == 0) begin
            if (req_gap > 0) req_gap--;
            req_tvalid <= 1'b0;
         end else begin
            req_tdata <= {7'd0, pending_access[0]};
            req_tvalid <= 1'b1;
         end
      end
   end

   // monitor: random backpressure, compare each response with the oldest expectation
   int rsp_gap = 0;
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[3:0]);
            if (rsp_tdata[7:4] != 4'd0) report("response pad bits not zero");
            if (expected_rsp.size() == 0) begin
               report("response transaction with nothing expected");
            end else begin
               want = expected_rsp.pop_front();
               checked++;
               if (want.hit) hit_count++;
               if (want.reads == 2) prefetch_count++;
               if (got.hit != want.hit)
                  report($sformatf("hit %0b want %0b", got.hit, want.hit));
               if (got.reads != want.reads)
                  report($sformatf("memory_reads %0d want %0d", got.reads, want.reads));
               if (got.wr != want.wr)
                  report($sformatf("memory_write %0b want %0b", got.wr, want.wr));
            end
            rsp_gap = gap_len();
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_BITS'({idx, 2'b00}); csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_REPLACE_LRU: cfg_lru = val[0];
         REG_PREFETCH_ON: cfg_pf = val[0];
         REG_BLOCK_BITS:  cfg_block = val[3:0];
         REG_SET_BITS:    cfg_sets = val[3:0];
         default:         cfg_ways = val[3:0];
      endcase
   endtask

   // wait for the block to drain; a trailing pause covers a long scan
   task automatic drain();
      while (pending_access.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic configure(input bit lru, input bit pf, input logic [3:0] blk,
                            input logic [3:0] sb, input logic [3:0] ways);
      csr_write(REG_REPLACE_LRU, {31'd0, lru});
      csr_write(REG_PREFETCH_ON, {31'd0, pf});
      csr_write(REG_BLOCK_BITS, {28'd0, blk});
      csr_write(REG_SET_BITS, {28'd0, sb});
      csr_write(REG_WAYS, {28'd0, ways});
   endtask

   task automatic queue_access(input logic [47:0] a, input bit w);
      access_type acc;
      acc.address = a;
      acc.is_write = w;
      pending_access.push_back(acc);
   endtask

   // random traffic over a small working set so hits and evictions both occur
   task automatic random_phase(input int count);
      logic [47:0] pool[16];
      logic [47:0] a;
      for (int i = 0; i < 16; i++) pool[i] = 48'({$urandom(), $urandom()});
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: a = 48'({$urandom(), $urandom()});
            1, 2: a = pool[$urandom_range(0, 15)] + (48'd1 << cfg_block);
            default: a = pool[$urandom_range(0, 15)] ^ 48'($urandom_range(0, 3));
         endcase
         queue_access(a, 1'($urandom_range(0, 1)));
         if (i % 97 == 96) pool[$urandom_range(0, 15)] = 48'({$urandom(), $urandom()});
      end
   endtask

   initial begin
      stamp_now = 0;
      for (int i = 0; i < NSETS; i++) fills[i] = 0;
      cfg_lru = 1'b0; cfg_pf = 1'b0; cfg_block = 4'd5; cfg_sets = 4'd0; cfg_ways = 4'd1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, extremes of address
      queue_access(48'd0, 1'b0);
      queue_access(48'd0, 1'b1);
      queue_access(48'hffff_ffff_ffff, 1'b1);
      queue_access(48'h1f, 1'b0);
      drain();
      // lru with prefetch, all sets, ways above the maximum, wrap at top
      configure(1'b1, 1'b1, 4'd0, 4'd15, 4'd15);
      queue_access(48'hffff_ffff_ffff, 1'b0);
      queue_access(48'd0, 1'b1);
      queue_access(48'h0000_0000_0100, 1'b0);
      queue_access(48'h0000_0000_0200, 1'b0);
      queue_access(48'h0000_0000_0100, 1'b1);
      queue_access(48'haaaa_aaaa_aaaa, 1'b0);
      queue_access(48'h5555_5555_5555, 1'b1);
      drain();
      // ways zero acts as one; large block size
      configure(1'b0, 1'b1, 4'd15, 4'd8, 4'd0);
      queue_access(48'h8000_0000_0000, 1'b0);
      queue_access(48'h7fff_ffff_ffff, 1'b0);
      queue_access(48'h0000_0000_8000, 1'b1);
      drain();
      // lower the ways after sets have filled
      configure(1'b1, 1'b0, 4'd4, 4'd2, 4'd8);
      for (int i = 0; i < 10; i++) queue_access(48'(i) << 6, i[0]);
      drain();
      csr_write(REG_WAYS, 32'd2);
      queue_access(48'd0, 1'b0);
      queue_access(48'h240, 1'b0);
      drain();

      // random phases over a range of settings
      begin
         logic [3:0] blks[6];
         blks = '{4'd0, 4'd2, 4'd5, 4'd6, 4'd12, 4'd15};
         for (int ph = 0; ph < 8; ph++) begin
            configure(ph[0], ph[1], blks[$urandom_range(0, 5)],
                      (ph == 3) ? 4'd15 : 4'($urandom_range(0, 8)),
                      (ph == 5) ? 4'd8 : 4'($urandom_range(1, 8)));
            random_phase(100);
            if (ph == 2) begin
               // let everything in flight come back before more traffic
               while (expected_rsp.size() == 0) @(posedge clock);
               hold_req = 1'b1;
               while (expected_rsp.size() != 0 || req_tvalid) @(posedge clock);
               repeat (30) @(posedge clock);
               hold_req = 1'b0;
            end
            random_phase(100);
            drain();
         end
      end
      stim_done = 1'b1;

      $display("covered %0d accesses: %0d hits, %0d with a prefetch fill",
               accepted, hit_count, prefetch_count);
      $display("settings swept: fifo and lru, prefetch off and on, block/set/way extremes");
      if (error_count == 0 && checked == accepted && expected_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (expected_rsp.size() != 0) $display("%0d responses never arrived",
                                               expected_rsp.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

   // run time limit
   initial begin
      #20000000;
      $display("timeout");
      $display("Simulation FAILED");
      $finish;
   end

endmodule
